>>> design/efr_pkg.sv
// Package for the escaped frame receiver.
// Holds the link byte codes, the status codes and the structs used by the
// parser, the top level and the testbench. Depends on nothing.
package efr_pkg;

  // Link byte codes.
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;

  // Payload store geometry.
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned ADDR_W      = 5;

  // Result status codes.
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SUM = 2'd1;
  localparam logic [1:0] STAT_LEN = 2'd2;

  // One result word.
  typedef struct packed {
    logic [7:0]        frame_code;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_index;
    logic [5:0]        payload_len;
    logic              has_data;
    logic              last;
    logic [1:0]        status;
  } res_t;

  // Write port into the payload store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // What an accepted byte triggers: a single result word or a payload readout.
  typedef struct packed {
    logic       single_v;
    res_t       single;
    logic       run_v;
    logic [7:0] run_code;
    logic [5:0] run_len;
  } evt_t;

endpackage

>>> design/efr_if.sv
// Channel interfaces of the escaped frame receiver.
// efr_byte_if carries received link bytes, efr_result_if carries result words.
// Depends on nothing.
interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_code;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic [5:0] payload_len;
  logic       has_data;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output frame_code, output data_byte, output byte_index,
                  output payload_len, output has_data, output last, output status,
                  input ready);
  modport sink (input valid, input frame_code, input data_byte, input byte_index,
                input payload_len, input has_data, input last, input status,
                output ready);
endinterface

>>> design/efr_parser.sv
// Byte-level frame parser: unescaping, length check, checksum and store writes.
// Depends on efr_pkg for byte codes, status codes and the wr_t / evt_t structs.
module efr_parser #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      byte_i,
  output efr_pkg::wr_t    wr_o,
  output efr_pkg::evt_t   evt_o
);

  // Largest legal length byte: the code byte plus a full payload.
  localparam int unsigned CAP     = (PAYLOAD_MAX > efr_pkg::STORE_DEPTH) ?
                                    efr_pkg::STORE_DEPTH : PAYLOAD_MAX;
  localparam logic [7:0]  LEN_MAX = 8'(CAP + 1);

  logic [5:0] pos_q, pos_d;
  logic [5:0] flen_q, flen_d;
  logic [7:0] code_q, code_d;
  logic [7:0] sum_q, sum_d;
  logic       esc_q, esc_d;
  logic       err_q, err_d;

  logic [7:0] ub;
  logic [7:0] sum_n;
  logic [5:0] n_len;

  assign ub    = esc_q ? (byte_i ^ efr_pkg::ESC_MASK) : byte_i;
  assign sum_n = sum_q + ub;
  assign n_len = flen_q - 6'd1;

  // Next state and events for one accepted byte.
  always_comb begin
    pos_d  = pos_q;
    flen_d = flen_q;
    code_d = code_q;
    sum_d  = sum_q;
    esc_d  = esc_q;
    err_d  = err_q;
    wr_o   = '0;
    evt_o  = '0;
    wr_o.data = ub;
    wr_o.addr = efr_pkg::ADDR_W'(pos_q - 6'd3);

    if (byte_valid_i) begin
      priority if (err_q) begin
        // Everything is dropped until the next start byte.
        if (byte_i == efr_pkg::FLAG_BYTE) begin
          err_d = 1'b0;
          sum_d = '0;
          esc_d = 1'b0;
          pos_d = 6'd1;
        end
      end else if (pos_q == 6'd0) begin
        // Idle: only a start byte opens a frame.
        if (byte_i == efr_pkg::FLAG_BYTE) begin
          pos_d = 6'd1;
          sum_d = '0;
          esc_d = 1'b0;
        end
      end else if (byte_i == efr_pkg::FLAG_BYTE) begin
        err_d = 1'b1;
      end else if (byte_i == efr_pkg::ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (pos_q == 6'd1) begin
          // Length byte.
          if (ub == 8'd0 || ub > LEN_MAX) begin
            err_d                 = 1'b1;
            pos_d                 = 6'd0;
            evt_o.single_v        = 1'b1;
            evt_o.single.last     = 1'b1;
            evt_o.single.status   = efr_pkg::STAT_LEN;
          end else begin
            flen_d = ub[5:0];
            pos_d  = 6'd2;
          end
        end else begin
          sum_d = sum_n;
          if (pos_q == 6'd2) begin
            code_d = ub;
            pos_d  = 6'd3;
          end else if (pos_q == flen_q + 6'd2) begin
            // Checksum byte closes the frame.
            pos_d = 6'd0;
            sum_d = '0;
            if (sum_n != efr_pkg::SUM_GOOD) begin
              err_d                   = 1'b1;
              evt_o.single_v          = 1'b1;
              evt_o.single.frame_code = code_q;
              evt_o.single.payload_len = n_len;
              evt_o.single.last       = 1'b1;
              evt_o.single.status     = efr_pkg::STAT_SUM;
            end else if (n_len == 6'd0) begin
              evt_o.single_v          = 1'b1;
              evt_o.single.frame_code = code_q;
              evt_o.single.last       = 1'b1;
              evt_o.single.status     = efr_pkg::STAT_OK;
            end else begin
              evt_o.run_v    = 1'b1;
              evt_o.run_code = code_q;
              evt_o.run_len  = n_len;
            end
          end else begin
            // Payload byte goes to the store.
            wr_o.en = 1'b1;
            pos_d   = pos_q + 6'd1;
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      flen_q <= '0;
      code_q <= '0;
      sum_q  <= '0;
      esc_q  <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      flen_q <= flen_d;
      code_q <= code_d;
      sum_q  <= sum_d;
      esc_q  <= esc_d;
      err_q  <= err_d;
    end
  end

endmodule

>>> design/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: parser, payload store, readout.
// Depends on efr_pkg, efr_byte_if / efr_result_if and efr_parser.
//
// Usage: raw link bytes enter on rx_i, one word per accepted byte. Frames
// are 0x7E, length, code, payload, checksum, with 0x7D escaping the next
// byte (XOR 0x20). Result words leave on res_o through an output register.
// While bytes are parsed and res_o does not stall, rx_i takes one byte per cycle;
// payload bytes go into a 32-entry store with a registered synchronous read. A
// bad length byte, a bad checksum byte or a good frame with no payload
// yields one result word in the next cycle. A good frame with n payload bytes
// starts a readout that reads the store one entry per cycle while res_o does
// not stall, and rx_i stays low until the last of the n words is in the
// output register. The single read port of the store sets this pace.
// When res_o stalls, the output register holds its word, the readout
// pauses, and rx_i is held off until the register can take a new word.
// Reset clears the parser, the readout and the output register; the store
// contents are left as they are, since a frame reads only what it wrote.
module escaped_frame_receiver #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  efr_byte_if.sink            rx_i,
  efr_result_if.source        res_o
);

  typedef enum logic {
    ST_PARSE,
    ST_RUN
  } state_e;

  localparam int unsigned AW = efr_pkg::ADDR_W;

  state_e             state_q;
  efr_pkg::wr_t       wr;
  efr_pkg::evt_t      evt;
  efr_pkg::res_t      res_q;
  logic               out_valid_q;
  logic               out_free;
  logic               in_ready;
  logic               in_acc;

  logic [7:0]         store [efr_pkg::STORE_DEPTH];
  logic [7:0]         rd_data_q;
  logic [AW-1:0]      rd_idx_q;
  logic               rd_pend_q;
  logic [5:0]         rd_cnt_q;
  logic [5:0]         run_len_q;
  logic [7:0]         run_code_q;
  logic               rd_en;
  logic               load;

  // Handshake on the byte channel.
  assign out_free   = !out_valid_q || res_o.ready;
  assign in_ready   = (state_q == ST_PARSE) && out_free;
  assign rx_i.ready = in_ready;
  assign in_acc     = rx_i.valid && in_ready;

  efr_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_acc),
    .byte_i       (rx_i.rx_byte),
    .wr_o         (wr),
    .evt_o        (evt)
  );

  // Readout: issue a read when the data stage is empty or drains this cycle.
  assign load  = (state_q == ST_RUN) && rd_pend_q && out_free;
  assign rd_en = (state_q == ST_RUN) && (rd_cnt_q != run_len_q) && (!rd_pend_q || load);

  // Payload store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_q <= store[rd_cnt_q[AW-1:0]];
      rd_idx_q  <= rd_cnt_q[AW-1:0];
    end
  end

  // Readout control and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      rd_pend_q   <= 1'b0;
      rd_cnt_q    <= '0;
      run_len_q   <= '0;
      run_code_q  <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      unique case (state_q)
        ST_PARSE: begin
          if (evt.run_v) begin
            state_q    <= ST_RUN;
            rd_cnt_q   <= '0;
            run_len_q  <= evt.run_len;
            run_code_q <= evt.run_code;
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + 6'd1;
          end
          if (rd_cnt_q == run_len_q && (!rd_pend_q || load)) begin
            state_q <= ST_PARSE;
          end
        end
        default: begin
          state_q <= ST_PARSE;
        end
      endcase

      if (rd_en) begin
        rd_pend_q <= 1'b1;
      end else if (load) begin
        rd_pend_q <= 1'b0;
      end

      priority if (evt.single_v) begin
        out_valid_q <= 1'b1;
        res_q       <= evt.single;
      end else if (load) begin
        out_valid_q       <= 1'b1;
        res_q.frame_code  <= run_code_q;
        res_q.data_byte   <= rd_data_q;
        res_q.byte_index  <= rd_idx_q;
        res_q.payload_len <= run_len_q;
        res_q.has_data    <= 1'b1;
        res_q.last        <= ({1'b0, rd_idx_q} + 6'd1) == run_len_q;
        res_q.status      <= efr_pkg::STAT_OK;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result channel.
  assign res_o.valid       = out_valid_q;
  assign res_o.frame_code  = res_q.frame_code;
  assign res_o.data_byte   = res_q.data_byte;
  assign res_o.byte_index  = res_q.byte_index;
  assign res_o.payload_len = res_q.payload_len;
  assign res_o.has_data    = res_q.has_data;
  assign res_o.last        = res_q.last;
  assign res_o.status      = res_q.status;

endmodule

>>> design/efr_checker.sv
// Port-level checker for the escaped frame receiver, bound to the top level.
// Depends on efr_pkg for status codes and on the top level's ports.
module efr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_code_i,
  input logic [7:0] data_byte_i,
  input logic [4:0] byte_index_i,
  input logic [5:0] payload_len_i,
  input logic       has_data_i,
  input logic       last_i,
  input logic [1:0] status_i
);

  // A stalled word holds its data, index, status and last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_byte_i)
      && $stable(byte_index_i) && $stable(status_i) && $stable(last_i))
    else $error("result word changed while stalled");

  // Payload words only come from good frames.
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_data_i |-> status_i == efr_pkg::STAT_OK)
    else $error("payload word with error status");

  // A word without payload carries zero data and index and is marked last.
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_data_i |-> data_byte_i == 8'd0 && byte_index_i == 5'd0 && last_i)
    else $error("word without payload has stray fields");

  // A length error clears code and length.
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == efr_pkg::STAT_LEN |->
      frame_code_i == 8'd0 && payload_len_i == 6'd0 && !has_data_i)
    else $error("length error word has stray fields");

  // No byte is taken while a payload run is still being delivered.
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_data_i && !last_i |-> !in_ready_i)
    else $error("byte accepted during payload readout");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .frame_code_i  (res_o.frame_code),
  .data_byte_i   (res_o.data_byte),
  .byte_index_i  (res_o.byte_index),
  .payload_len_i (res_o.payload_len),
  .has_data_i    (res_o.has_data),
  .last_i        (res_o.last),
  .status_i      (res_o.status)
);

>>> bench/tb.sv
// Self-checking testbench for escaped_frame_receiver: directed link bytes, then random
// framed traffic in four handshake mixes, scored by a frame parser or typed words.
// Depends on efr_pkg, efr_byte_if / efr_result_if and the receiver RTL.
module tb;

  localparam int unsigned PAYLOAD_CAP    = 32;
  localparam int unsigned CAPACITY       = (PAYLOAD_CAP > efr_pkg::STORE_DEPTH) ?
                                           efr_pkg::STORE_DEPTH : PAYLOAD_CAP;
  localparam int unsigned RAND_PER_PHASE = 56;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 80;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int unsigned SRC_IDLE [4]  = '{0, 45, 0, 15};
  localparam int unsigned SNK_STALL [4] = '{0, 0, 45, 15};

  // One directed row: link byte, flag for a hand-written result word, that word.
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    efr_pkg::res_t word;
  } dir_row_t;

  localparam efr_pkg::res_t LEN_ERR_WORD = {8'h00, 8'h00, 5'd0, 6'd0, 1'b0, 1'b1,
                                            efr_pkg::STAT_LEN};

  localparam int unsigned DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {8'h00, 1'b0, 31'd0},                 // idle byte, ignored
    {efr_pkg::ESC_BYTE, 1'b0, 31'd0},     // escape while idle, ignored
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},
    {8'h00, 1'b1, LEN_ERR_WORD},          // zero length
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},    // leaves the error state
    {8'h22, 1'b1, LEN_ERR_WORD},          // payload of 33 is over capacity
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},
    {8'h01, 1'b0, 31'd0},                 // empty payload
    {efr_pkg::ESC_BYTE, 1'b0, 31'd0},
    {8'h5D, 1'b0, 31'd0},                 // code 0x7D through an escape
    {8'h82, 1'b1, {8'h7D, 8'h00, 5'd0, 6'd0, 1'b0, 1'b1, efr_pkg::STAT_OK}},
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},
    {8'h02, 1'b0, 31'd0},
    {8'hFF, 1'b0, 31'd0},
    {8'h00, 1'b0, 31'd0},
    {8'h01, 1'b1, {8'hFF, 8'h00, 5'd0, 6'd1, 1'b0, 1'b1, efr_pkg::STAT_SUM}}, // bad checksum
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},    // start inside a frame
    {efr_pkg::FLAG_BYTE, 1'b0, 31'd0},
    {8'h03, 1'b0, 31'd0},
    {efr_pkg::ESC_BYTE, 1'b0, 31'd0},
    {efr_pkg::ESC_BYTE, 1'b0, 31'd0},     // repeated escape stays pending
    {8'h5E, 1'b0, 31'd0},                 // code 0x7E
    {8'hFF, 1'b0, 31'd0},
    {8'h00, 1'b0, 31'd0},
    {8'h82, 1'b0, 31'd0}                  // good checksum, two payload words
  };

  logic clk_i;
  logic rst_ni;

  efr_byte_if   rx_if ();
  efr_result_if res_if ();

  escaped_frame_receiver #(
    .PAYLOAD_MAX(PAYLOAD_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // Parser state mirrored from the frame format.
  logic [5:0] frame_pos;
  logic [7:0] frame_len;
  logic [7:0] frame_code;
  logic [7:0] frame_sum;
  logic       esc_pending;
  logic       wait_flag;
  logic [7:0] payload_mem [efr_pkg::STORE_DEPTH];

  efr_pkg::res_t fresh_words [$];
  efr_pkg::res_t pending_words [$];
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;
  int unsigned   bytes_in;
  int unsigned   items_in;
  int unsigned   words_checked;
  int unsigned   mismatches;
  int unsigned   quiet_cycles;
  efr_pkg::res_t got_word;
  efr_pkg::res_t want_word;

  function automatic efr_pkg::res_t pack_word(input logic [7:0] code,
                                              input logic [7:0] data,
                                              input logic [4:0] idx, input logic [5:0] len,
                                              input logic has, input logic lst,
                                              input logic [1:0] st);
    return {code, data, idx, len, has, lst, st};
  endfunction

  // Advances the frame parser by one link byte and leaves the words it emits in
  // fresh_words. Returns 1 when the byte is ignored outright.
  function automatic bit parse_link_byte(input logic [7:0] raw);
    logic [7:0]  b;
    int unsigned n;
    b = raw;
    fresh_words.delete();
    // After an error only a start byte is seen; it also opens a new frame.
    if (wait_flag) begin
      if (b != efr_pkg::FLAG_BYTE) return 1'b1;
      wait_flag   = 1'b0;
      frame_sum   = '0;
      esc_pending = 1'b0;
      frame_pos   = 6'd1;
      return 1'b0;
    end
    if (frame_pos == 6'd0) begin
      if (b != efr_pkg::FLAG_BYTE) return 1'b1;
      frame_pos   = 6'd1;
      frame_sum   = '0;
      esc_pending = 1'b0;
      return 1'b0;
    end
    if (b == efr_pkg::FLAG_BYTE) begin
      wait_flag = 1'b1;
      return 1'b0;
    end
    if (b == efr_pkg::ESC_BYTE) begin
      esc_pending = 1'b1;
      return 1'b0;
    end
    if (esc_pending) begin
      b           = b ^ efr_pkg::ESC_MASK;
      esc_pending = 1'b0;
    end
    // Length byte: counts the code byte plus the payload.
    if (frame_pos == 6'd1) begin
      if (b == 8'd0 || int'(b) - 1 > int'(CAPACITY)) begin
        wait_flag = 1'b1;
        frame_pos = 6'd0;
        fresh_words.push_back(pack_word(8'h00, 8'h00, 5'd0, 6'd0, 1'b0, 1'b1,
                                        efr_pkg::STAT_LEN));
        return 1'b0;
      end
      frame_len = b;
      frame_pos = 6'd2;
      return 1'b0;
    end
    frame_sum = frame_sum + b;
    if (frame_pos == 6'd2) begin
      frame_code = b;
      frame_pos  = 6'd3;
      return 1'b0;
    end
    // Checksum byte closes the frame.
    if (int'(frame_pos) == int'(frame_len) + 2) begin
      n         = int'(frame_len) - 1;
      frame_pos = 6'd0;
      if (frame_sum != efr_pkg::SUM_GOOD) begin
        wait_flag = 1'b1;
        fresh_words.push_back(pack_word(frame_code, 8'h00, 5'd0, 6'(n), 1'b0, 1'b1,
                                        efr_pkg::STAT_SUM));
      end else if (n == 0) begin
        fresh_words.push_back(pack_word(frame_code, 8'h00, 5'd0, 6'd0, 1'b0, 1'b1,
                                        efr_pkg::STAT_OK));
      end else begin
        for (int unsigned k = 0; k < n && k < efr_pkg::STORE_DEPTH; k++)
          fresh_words.push_back(pack_word(frame_code, payload_mem[5'(k)], 5'(k), 6'(n),
                                          1'b1, (k + 1 == n), efr_pkg::STAT_OK));
      end
      frame_sum = '0;
      return 1'b0;
    end
    if (int'(frame_pos) - 3 < int'(efr_pkg::STORE_DEPTH))
      payload_mem[5'(frame_pos - 6'd3)] = b;
    frame_pos = frame_pos + 6'd1;
    return 1'b0;
  endfunction

  // Offers one link byte at a falling edge and returns at the falling edge after
  // the word is taken. A typed word replaces the parser's prediction.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input efr_pkg::res_t typed_word = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid = 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_in++;
    if (!parse_link_byte(b)) items_in++;
    if (typed) begin
      pending_words.push_back(typed_word);
    end else begin
      foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    end
    @(negedge clk_i);
  endtask

  // Sends a frame-level byte, escaping specials and now and then an ordinary one.
  task automatic send_escaped(input logic [7:0] v);
    logic [7:0] flipped;
    flipped = v ^ efr_pkg::ESC_MASK;
    if (v == efr_pkg::FLAG_BYTE || v == efr_pkg::ESC_BYTE ||
        ($urandom_range(9) == 0 && flipped != efr_pkg::FLAG_BYTE &&
         flipped != efr_pkg::ESC_BYTE)) begin
      if ($urandom_range(19) == 0) send_byte(efr_pkg::ESC_BYTE);
      send_byte(efr_pkg::ESC_BYTE);
      send_byte(flipped);
    end else begin
      send_byte(v);
    end
  endtask

  // One random chunk of link traffic: mostly well-formed frames with random
  // content, plus bad lengths, cut-off frames and line noise.
  task automatic send_random_chunk();
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  sum;
    logic [7:0]  data;
    logic [7:0]  chk;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_byte(efr_pkg::FLAG_BYTE);
      send_escaped($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 34)));
    end else if (kind < 15) begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (kind < 21) begin
      // Frame mostly cut short; the next start byte then lands inside it.
      send_byte(efr_pkg::FLAG_BYTE);
      send_escaped(8'($urandom_range(9, 2)));
      n = $urandom_range(3);
      repeat (n) send_escaped(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) send_byte(efr_pkg::FLAG_BYTE);
    end else begin
      pick = $urandom_range(99);
      if (pick < 6) n = 32;
      else if (pick < 14) n = $urandom_range(31, 9);
      else n = $urandom_range(8);
      code = 8'($urandom_range(255));
      sum  = code;
      send_byte(efr_pkg::FLAG_BYTE);
      send_escaped(8'(n + 1));
      send_escaped(code);
      repeat (n) begin
        data = 8'($urandom_range(255));
        sum  = sum + data;
        send_escaped(data);
      end
      chk = efr_pkg::SUM_GOOD - sum;
      if ($urandom_range(99) < 12) chk = chk ^ 8'($urandom_range(255, 1));
      send_escaped(chk);
      if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Holds the sender off until every predicted word has come out.
  task automatic drain_results();
    rx_if.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, driven at the falling edge.
  always @(negedge clk_i) begin
    res_if.ready = ($urandom_range(99) >= snk_stall_pct);
  end

  // Score every result word taken at a rising edge against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_word = {res_if.frame_code, res_if.data_byte, res_if.byte_index, res_if.payload_len,
                  res_if.has_data, res_if.last, res_if.status};
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got 0x%08h", $time, got_word);
      end else begin
        want_word = pending_words.pop_front();
        words_checked++;
        check_field("frame_code", want_word.frame_code, got_word.frame_code);
        check_field("data_byte", want_word.data_byte, got_word.data_byte);
        check_field("byte_index", 8'(want_word.byte_index), 8'(got_word.byte_index));
        check_field("payload_len", 8'(want_word.payload_len), 8'(got_word.payload_len));
        check_field("has_data", 8'(want_word.has_data), 8'(got_word.has_data));
        check_field("last", 8'(want_word.last), 8'(got_word.last));
        check_field("status", 8'(want_word.status), 8'(got_word.status));
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results still due", $time,
                 QUIET_LIMIT, pending_words.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed rows, then four phases of random traffic.
  initial begin
    int unsigned ph;
    int unsigned base;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    bytes_in      = 0;
    items_in      = 0;
    words_checked = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    frame_pos     = '0;
    frame_len     = '0;
    frame_code    = '0;
    frame_sum     = '0;
    esc_pending   = 1'b0;
    wait_flag     = 1'b0;
    foreach (payload_mem[i]) payload_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].word);
    drain_results();

    // Each phase sends about RAND_PER_PHASE link bytes.
    base = bytes_in;
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SRC_IDLE[ph];
      snk_stall_pct = SNK_STALL[ph];
      while (bytes_in < base + (ph + 1) * RAND_PER_PHASE) send_random_chunk();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d link bytes (%0d parsed) in directed and four handshake mixes;",
             bytes_in, items_in);
    $display("checked %0d result words, %0d field mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/efr_pkg.sv
design/efr_if.sv
design/efr_parser.sv
design/escaped_frame_receiver.sv
design/efr_checker.sv
bench/tb.sv
